/* rtl/tst_pkg.sv */
package tst_pkg;

  // Fixed field widths of the stream items
  localparam int CMD_W      = 2;
  localparam int SYM_W      = 8;
  localparam int STOP_W     = 32;
  localparam int PRICE_LSB  = CMD_W + SYM_W;
  localparam int OUT_W      = ((SYM_W + STOP_W + 7) / 8) * 8;

  // Entry price is split at this bit for the two partial products
  localparam int SPLIT_BITS = 24;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_QUOTE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEL   = 2'd2;

  // Table write source select
  localparam logic [1:0] WR_SET  = 2'd0;
  localparam logic [1:0] WR_DEL  = 2'd1;
  localparam logic [1:0] WR_CLR  = 2'd2;
  localparam logic [1:0] WR_BACK = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic       acc;        // input beat taken, table read issued
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       mul_hi;     // multiplier takes upper price slice
    logic       hm_load;
    logic       lo_load;
    logic       step_load;
    logic       diff_load;
    logic       clr_step;
    logic       out_load;
  } tst_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_quote;
    logic in_set;
    logic in_del;
    logic entry_ok;
    logic trip;
    logic clr_done;
  } tst_stat_t;

endpackage

/* rtl/trailing_stop_table.sv */
// Channel | Direction | Handshake              | Payload (low bit up)
// in      | slave     | in_tvalid / in_tready   | cmd, symbol_index, price, fraction
// out     | master    | out_tvalid / out_tready | sell_symbol, stop_level
//
// Set and delete write the table in the cycle their beat is taken. A quote on a
// set slot steps through table read, two partial products on one shared
// multiplier, sum, subtract, and compare with write back; a quote on an empty
// slot ends after the table read. After reset a clearing pass writes every
// table slot with in_tready low. A quote that trips waits in its last step
// while a prior result is still held; new beats are taken while a result waits.
module trailing_stop_table
  import tst_pkg::*;
#(
  parameter int SYMBOLS       = 256,
  parameter int PRICE_BITS    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // cmd, symbol_index, price, fraction
  input  logic [((PRICE_LSB+PRICE_BITS+FRACTION_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // sell_symbol, stop_level
  output logic [OUT_W-1:0] out_tdata
);

  localparam int IN_W = ((PRICE_LSB + PRICE_BITS + FRACTION_BITS + 7) / 8) * 8;

  tst_cmd_t  cmd;
  tst_stat_t stat;

  tst_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  tst_dp #(
    .SYMBOLS       (SYMBOLS),
    .PRICE_BITS    (PRICE_BITS),
    .FRACTION_BITS (FRACTION_BITS),
    .IN_W          (IN_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

/* rtl/tst_ram.sv */
module tst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/tst_dp.sv */
module tst_dp
  import tst_pkg::*;
#(
  parameter int SYMBOLS       = 256,
  parameter int PRICE_BITS    = 32,
  parameter int FRACTION_BITS = 16,
  parameter int IN_W          = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [IN_W-1:0] in_tdata,   // cmd, symbol_index, price, fraction
  output logic [OUT_W-1:0] out_tdata, // sell_symbol, stop_level
  input  tst_cmd_t        cmd,
  output tst_stat_t       stat
);

  localparam int ADDR_W  = $clog2(SYMBOLS);
  localparam int IDX_W   = (ADDR_W > SYM_W) ? ADDR_W : SYM_W;
  localparam int ENTRY_W = 2 * PRICE_BITS + FRACTION_BITS + 1;
  localparam int LO_W    = (PRICE_BITS < SPLIT_BITS) ? PRICE_BITS : SPLIT_BITS;
  localparam int MUL_W   = LO_W + FRACTION_BITS;
  localparam int SUM_W   = LO_W + SPLIT_BITS + 1;
  localparam int SHL     = SPLIT_BITS - FRACTION_BITS;
  localparam int FRAC_LSB = PRICE_LSB + PRICE_BITS;
  localparam int VALID_B = ENTRY_W - 1;

  // Input unpack
  logic [CMD_W-1:0]         in_cmd;
  logic [SYM_W-1:0]         in_sym;
  logic [PRICE_BITS-1:0]    in_price;
  logic [FRACTION_BITS-1:0] in_frac;
  logic [IDX_W-1:0]         in_idx;
  logic [ADDR_W-1:0]        in_addr;
  logic                     in_range;

  assign in_cmd   = in_tdata[CMD_W-1:0];
  assign in_sym   = in_tdata[PRICE_LSB-1:CMD_W];
  assign in_price = in_tdata[FRAC_LSB-1:PRICE_LSB];
  assign in_frac  = in_tdata[FRAC_LSB+FRACTION_BITS-1:FRAC_LSB];
  assign in_idx   = IDX_W'(in_sym);
  assign in_addr  = in_idx[ADDR_W-1:0];
  assign in_range = {1'b0, in_idx} < (IDX_W+1)'(SYMBOLS);

  assign stat.in_quote = in_range && (in_cmd == CMD_QUOTE);
  assign stat.in_set   = in_range && (in_cmd == CMD_SET);
  assign stat.in_del   = in_range && (in_cmd == CMD_DEL);

  // Working registers of one quote
  logic [PRICE_BITS-1:0] price_r;
  logic [SYM_W-1:0]      sym_r;
  logic [ADDR_W-1:0]     addr_r;
  logic [ADDR_W-1:0]     clr_r, clr_nxt;
  logic [PRICE_BITS-1:0] hm_r;
  logic [MUL_W-1:0]      mul_r;
  logic [LO_W-1:0]       lo_part_r;
  logic [PRICE_BITS-1:0] step_r;
  logic [PRICE_BITS-1:0] stop_r;
  logic                  neg_r;
  logic [SYM_W-1:0]      out_sym_r;
  logic [STOP_W-1:0]     out_stop_r;

  // Table
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ENTRY_W-1:0]    wr_data;
  logic [ENTRY_W-1:0]    rd_data;
  logic [PRICE_BITS-1:0] rd_ep;
  logic [PRICE_BITS-1:0] rd_hm;
  logic [FRACTION_BITS-1:0] rd_frac;

  assign rd_ep   = rd_data[PRICE_BITS-1:0];
  assign rd_hm   = rd_data[2*PRICE_BITS-1:PRICE_BITS];
  assign rd_frac = rd_data[2*PRICE_BITS+FRACTION_BITS-1:2*PRICE_BITS];
  assign stat.entry_ok = rd_data[VALID_B];

  tst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SYMBOLS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.acc),
    .rd_addr (in_addr),
    .rd_data (rd_data)
  );

  // Write source select
  always_comb begin
    wr_en   = cmd.wr_en;
    wr_addr = in_addr;
    wr_data = '0;
    case (cmd.wr_sel)
      WR_SET: begin
        wr_data = {1'b1, in_frac, in_price, in_price};
      end
      WR_DEL: begin
        wr_data = '0;
      end
      WR_CLR: begin
        wr_addr = clr_r;
        wr_data = '0;
      end
      WR_BACK: begin
        wr_addr = addr_r;
        wr_data = {1'b1, rd_frac, hm_r, rd_ep};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Clearing pass counter
  assign clr_nxt       = cmd.clr_step ? clr_r + 1'b1 : clr_r;
  assign stat.clr_done = (clr_r == ADDR_W'(SYMBOLS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else begin
      clr_r <= clr_nxt;
    end
  end

  // Shared multiplier: lower slice first, then upper slice
  logic [PRICE_BITS-1:0] ep_hi_full;
  logic [LO_W-1:0]       mul_a;
  logic [SUM_W-1:0]      step_sum;
  logic [PRICE_BITS:0]   diff;

  assign ep_hi_full = rd_ep >> SPLIT_BITS;
  assign mul_a      = cmd.mul_hi ? LO_W'(ep_hi_full) : LO_W'(rd_ep);
  assign step_sum   = (SUM_W'(mul_r) << SHL) + SUM_W'(lo_part_r);
  assign diff       = {1'b0, hm_r} - {1'b0, step_r};

  assign stat.trip = !neg_r && (price_r < stop_r);

  always_ff @(posedge clk) begin
    mul_r <= MUL_W'(mul_a) * MUL_W'(rd_frac);
    if (cmd.acc) begin
      price_r <= in_price;
      sym_r   <= in_sym;
      addr_r  <= in_addr;
    end
    // raise the high mark
    if (cmd.hm_load) begin
      hm_r <= (price_r > rd_hm) ? price_r : rd_hm;
    end
    if (cmd.lo_load) begin
      lo_part_r <= mul_r[MUL_W-1:FRACTION_BITS];
    end
    if (cmd.step_load) begin
      step_r <= PRICE_BITS'(step_sum);
    end
    // borrow out means a negative stop level
    if (cmd.diff_load) begin
      neg_r  <= diff[PRICE_BITS];
      stop_r <= diff[PRICE_BITS-1:0];
    end
    if (cmd.out_load) begin
      out_sym_r  <= sym_r;
      out_stop_r <= STOP_W'(stop_r);
    end
  end

  assign out_tdata = OUT_W'({out_stop_r, out_sym_r});

endmodule

/* rtl/tst_ctrl.sv */
module tst_ctrl
  import tst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  tst_stat_t stat,
  output tst_cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LO    = 3'd2;
  localparam logic [2:0] S_HI    = 3'd3;
  localparam logic [2:0] S_SUM   = 3'd4;
  localparam logic [2:0] S_DIFF  = 3'd5;
  localparam logic [2:0] S_EVAL  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       go;

  // result slot free, or no result to place
  assign go = !stat.trip || !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_sel   = WR_CLR;
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.acc = 1'b1;
          if (stat.in_set) begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_SET;
          end else if (stat.in_del) begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_DEL;
          end else if (stat.in_quote) begin
            state_nxt = S_LO;
          end
        end
      end
      S_LO: begin
        cmd.hm_load = 1'b1;
        state_nxt   = stat.entry_ok ? S_HI : S_IDLE;
      end
      S_HI: begin
        cmd.lo_load = 1'b1;
        cmd.mul_hi  = 1'b1;
        state_nxt   = S_SUM;
      end
      S_SUM: begin
        cmd.step_load = 1'b1;
        state_nxt     = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff_load = 1'b1;
        state_nxt     = S_EVAL;
      end
      S_EVAL: begin
        if (go) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_sel   = WR_BACK;
          cmd.out_load = stat.trip;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

/* rtl/tst_checker.sv */
module tst_checker
  import tst_pkg::*;
#(
  parameter int SYMBOLS       = 256,
  parameter int PRICE_BITS    = 32,
  parameter int FRACTION_BITS = 16
) (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic [((PRICE_LSB+PRICE_BITS+FRACTION_BITS+7)/8)*8-1:0] in_tdata,
  input logic out_tvalid,
  input logic out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  logic quote_beat;

  assign quote_beat = in_tvalid && in_tready &&
                      (in_tdata[CMD_W-1:0] == CMD_QUOTE) &&
                      (32'(in_tdata[PRICE_LSB-1:CMD_W]) < SYMBOLS);

  // reset starts the clearing pass and drops any result
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("input ready or result valid right after reset");

  // a quote holds off the input for its evaluation
  a_quote_busy: assert property (@(posedge clk) disable iff (!rst_n)
    quote_beat |=> !in_tready)
    else $error("input ready in the cycle after a quote beat");

  // a new result only comes out of a quote evaluation
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared while input side was idle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result data changed while stalled");

endmodule

bind trailing_stop_table tst_checker #(
  .SYMBOLS       (SYMBOLS),
  .PRICE_BITS    (PRICE_BITS),
  .FRACTION_BITS (FRACTION_BITS)
) u_tst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
